// File: sv/extent_free_list_block_allocator_defines.svh
// ------------------------------------------------------------------------
// extent free list block allocator assertion macros
// shared property forms, clocked on i_clk and held off during reset
// ------------------------------------------------------------------------
`ifndef EXTENT_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define EXTENT_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define EFLBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EFLBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/eflba_pkg.sv
// ------------------------------------------------------------------------
// eflba_pkg
// shared codes and command types of the extent free list block allocator
// ------------------------------------------------------------------------
package eflba_pkg;

    // fixed field widths
    localparam int BLK_W  = 10;
    localparam int CFG_W  = 11;
    localparam int USED_W = 10;

    localparam logic [USED_W-1:0] USED_MAX = 10'd1023;

    typedef enum logic [1:0] {
        ACT_FORMAT = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNFORMATTED = 2'd1,
        ST_FULL        = 2'd2,
        ST_BAD         = 2'd3
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// File: sv/extent_free_list_block_allocator.sv
// ------------------------------------------------------------------------
// extent_free_list_block_allocator
// result: beat on o_done is registered from the execute state of the sequencer
// requests: a new request is taken only while busy is low, not during the
//   execute state, which uses the registered header read and writes the header memory
// reset: synchronous, clears head, used count, formatted flag, volume = 1024
// results cannot be stalled; busy is high while a request is in execution
// ------------------------------------------------------------------------
module extent_free_list_block_allocator
    import eflba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_action,
    input  logic [BLK_W-1:0]  i_block_to_free,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [BLK_W-1:0]  o_block,
    output logic [1:0]        o_status,
    output logic [USED_W-1:0] o_used_blocks
);

    t_dp_cmd cmd;

    // sequencer
    eflba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // list state and header memory
    eflba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_block_to_free (i_block_to_free),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_block         (o_block),
        .o_status        (o_status),
        .o_used_blocks   (o_used_blocks)
    );

endmodule

// File: sv/eflba_ctrl.sv
// ------------------------------------------------------------------------
// eflba_ctrl
// sequencer: takes a request, then runs the execute state on the datapath
// ------------------------------------------------------------------------
module eflba_ctrl
    import eflba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy       = r_busy;
    assign o_cmd.load = start && !r_busy;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

// File: sv/eflba_datapath.sv
// ------------------------------------------------------------------------
// eflba_datapath
// head pointer, used count, header memory and result registers
// ------------------------------------------------------------------------
`include "extent_free_list_block_allocator_defines.svh"

module eflba_datapath
    import eflba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_action,
    input  logic [BLK_W-1:0]  i_block_to_free,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [BLK_W-1:0]  o_block,
    output logic [1:0]        o_status,
    output logic [USED_W-1:0] o_used_blocks
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int VW = AW + 1;

    typedef struct packed {
        logic [AW-1:0] run;
        logic [AW-1:0] next;
    } t_hdr;

    // request and state registers
    t_action            r_action;
    logic [BLK_W-1:0]   r_blk;
    logic [CFG_W-1:0]   r_vol_blocks;
    logic [AW-1:0]      r_head;
    logic [USED_W-1:0]  r_used;
    logic               r_formatted;
    t_hdr               r_mem [MAX_BLOCKS];
    t_hdr               r_rd_data;

    logic [AW-1:0]      n_head;
    logic [USED_W-1:0]  n_used;
    logic               n_formatted;
    logic [AW-1:0]      got;
    t_status            status;
    logic               hdr_we;
    logic [AW-1:0]      hdr_addr;
    t_hdr               hdr_wdata;
    logic [31:0]        cfg_w;
    logic [VW-1:0]      vsize;

    // clamp volume size to 2..MAX_BLOCKS
    assign cfg_w = 32'(r_vol_blocks);
    always_comb begin
        if (cfg_w < 32'd2)
            vsize = VW'(2);
        else if (cfg_w > 32'(MAX_BLOCKS))
            vsize = VW'(MAX_BLOCKS);
        else
            vsize = VW'(cfg_w);
    end

    // execute one request
    always_comb begin
        n_head      = r_head;
        n_used      = r_used;
        n_formatted = r_formatted;
        got         = '0;
        status      = ST_OK;
        hdr_we      = 1'b0;
        hdr_addr    = r_head;
        hdr_wdata   = r_rd_data;
        unique case (r_action)
            ACT_FORMAT: begin
                n_head         = AW'(1);
                n_used         = '0;
                n_formatted    = 1'b1;
                hdr_we         = 1'b1;
                hdr_addr       = AW'(1);
                hdr_wdata.run  = AW'(vsize - VW'(1));
                hdr_wdata.next = '0;
            end
            ACT_ALLOC: begin
                if (!r_formatted) begin
                    status = ST_UNFORMATTED;
                end else if (r_head == '0) begin
                    status = ST_FULL;
                end else begin
                    got = r_head;
                    // single-block extent or end of store: follow the link
                    if (r_rd_data.run <= AW'(1) || r_head >= AW'(MAX_BLOCKS - 1)) begin
                        n_head = r_rd_data.next;
                    end else begin
                        n_head         = r_head + AW'(1);
                        hdr_we         = 1'b1;
                        hdr_addr       = r_head + AW'(1);
                        hdr_wdata.run  = r_rd_data.run - AW'(1);
                        hdr_wdata.next = r_rd_data.next;
                    end
                    if (r_used < USED_MAX) n_used = r_used + USED_W'(1);
                end
            end
            ACT_FREE: begin
                if (!r_formatted) begin
                    status = ST_UNFORMATTED;
                end else if (r_blk == '0 || 32'(r_blk) >= 32'(vsize)) begin
                    status = ST_BAD;
                end else begin
                    hdr_we         = 1'b1;
                    hdr_addr       = AW'(r_blk);
                    hdr_wdata.run  = AW'(1);
                    hdr_wdata.next = r_head;
                    n_head         = AW'(r_blk);
                    if (r_used != '0) n_used = r_used - USED_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // header memory, read port follows the head pointer
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_head];
        if (i_cmd.exec && hdr_we) r_mem[hdr_addr] <= hdr_wdata;
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_blk    <= i_block_to_free;
        end
        if (i_cmd.exec) begin
            o_block       <= BLK_W'(got);
            o_status      <= status;
            o_used_blocks <= n_used;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_blocks <= CFG_W'(1024);
            r_head       <= '0;
            r_used       <= '0;
            r_formatted  <= 1'b0;
            o_done       <= 1'b0;
        end else begin
            o_done <= i_cmd.exec;
            if (i_cfg_we) r_vol_blocks <= i_cfg_wdata;
            if (i_cmd.exec) begin
                r_head      <= n_head;
                r_used      <= n_used;
                r_formatted <= n_formatted;
            end
        end
    end

    // checks
    `EFLBA_ASSERT_NOW(a_load_not_exec, i_cmd.load, !i_cmd.exec, "load during execute")
    `EFLBA_ASSERT_NEXT(a_exec_gives_done, i_cmd.exec, o_done, "execute without result beat")
    `EFLBA_ASSERT_NOW(a_block_only_ok, o_done && o_block != '0, o_status == ST_OK,
        "block handed out with error status")
    `EFLBA_ASSERT_NEXT(a_format_sets_head, i_cmd.exec && r_action == ACT_FORMAT,
        r_formatted && r_head == AW'(1), "format did not reset the list")

endmodule
